### design/csct_pkg.sv
// Shared types and register codes for the cone and sphere contact test.
package csct_pkg;

    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_CONE_LENGTH     = 2'd0;
    localparam cfg_idx_t REG_CONE_END_RADIUS = 2'd1;

    // Status codes of a result item
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_RANGE_ERROR = 1'b1;

endpackage

### design/csct_if.sv
// Channel interfaces of the cone and sphere contact test: query, result and configuration.
interface csct_query_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic signed [W-1:0] sphere_x;
    logic signed [W-1:0] sphere_y;
    logic signed [W-1:0] sphere_z;
    logic signed [W-1:0] sphere_radius;
    logic                blocked;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    sphere_x, sphere_y, sphere_z, sphere_radius, blocked, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  sphere_x, sphere_y, sphere_z, sphere_radius, blocked, output ready);
endinterface

interface csct_result_if ();
    logic valid;
    logic ready;
    logic hit;
    logic status;

    modport source (output valid, hit, status, input ready);
    modport sink (input valid, hit, status, output ready);
endinterface

interface csct_cfg_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    csct_pkg::cfg_idx_t  index;
    logic signed [W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/csct_isqrt_pipe.sv
// Pipelined floor square root, one root bit per stage, with a sideband that travels along.
module csct_isqrt_pipe #(
    parameter int RW = 32,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    logic            v_w    [RW+1];
    logic [2*RW-1:0] n_w    [RW+1];
    logic [RW+1:0]   rem_w  [RW+1];
    logic [RW-1:0]   root_w [RW+1];
    logic [SW-1:0]   side_w [RW+1];

    assign v_w[0]    = in_valid;
    assign n_w[0]    = radicand;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign side_w[0] = side_in;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            v_reg;
        logic [2*RW-1:0] n_reg;
        logic [RW+1:0]   rem_reg;
        logic [RW-1:0]   root_reg;
        logic [SW-1:0]   side_reg;
        logic [RW+3:0]   shifted;
        logic [RW+3:0]   trial;
        logic            take;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   root_next;

        // Bring down the next pair of radicand bits and try root*4+1
        always_comb
        begin
            shifted   = {rem_w[k], n_w[k][2*RW-1 -: 2]};
            trial     = {2'b00, root_w[k], 2'b01};
            take      = (shifted >= trial);
            rem_next  = take ? (RW+2)'(shifted - trial) : shifted[RW+1:0];
            root_next = {root_w[k][RW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg    <= {n_w[k][2*RW-3:0], 2'b00};
                rem_reg  <= rem_next;
                root_reg <= root_next;
                side_reg <= side_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign n_w[k+1]    = n_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = v_w[RW];
    assign root      = root_w[RW];
    assign side_out  = side_w[RW];

endmodule

### design/csct_udiv_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
module csct_udiv_pipe #(
    parameter int QW = 31,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] num_low,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          v_w    [QW+1];
    logic [DW-1:0] rem_w  [QW+1];
    logic [QW-1:0] num_w  [QW+1];
    logic [QW-1:0] quo_w  [QW+1];
    logic [DW-1:0] den_w  [QW+1];
    logic [SW-1:0] side_w [QW+1];

    assign v_w[0]    = in_valid;
    assign rem_w[0]  = rem_init;
    assign num_w[0]  = num_low;
    assign quo_w[0]  = '0;
    assign den_w[0]  = divisor;
    assign side_w[0] = side_in;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_reg;
        logic [DW-1:0] rem_reg;
        logic [QW-1:0] num_reg;
        logic [QW-1:0] quo_reg;
        logic [DW-1:0] den_reg;
        logic [SW-1:0] side_reg;
        logic [DW:0]   shifted;
        logic          take;

        // Shift in the next dividend bit and subtract when it fits
        always_comb
        begin
            shifted = {rem_w[k], num_w[k][QW-1]};
            take    = (shifted >= {1'b0, den_w[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= take ? DW'(shifted - {1'b0, den_w[k]}) : shifted[DW-1:0];
                num_reg  <= {num_w[k][QW-2:0], 1'b0};
                quo_reg  <= {quo_w[k][QW-2:0], take};
                den_reg  <= den_w[k];
                side_reg <= side_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign rem_w[k+1]  = rem_reg;
        assign num_w[k+1]  = num_reg;
        assign quo_w[k+1]  = quo_reg;
        assign den_w[k+1]  = den_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = v_w[QW];
    assign quotient  = quo_w[QW];
    assign side_out  = side_w[QW];

endmodule

### design/cone_sphere_contact_test.sv
// Top level of the cone and sphere contact test: front products, root, two dividers, output queue.
//
// Usage:
//   query  - one item per contact test: cone origin and forward direction, sphere center and
//            radius, and the blocked flag. Accepted when valid and ready are both high.
//   result - one item per query, in query order: hit and status (status high on a range
//            error, and hit is then low).
//   cfg    - writes cone_length (index 0) and cone_end_radius (index 1); always ready.
//            Write only while no query is in flight.
// Throughput: one query per cycle while the output queue has room. The pipe runs through the
// square root pipeline (one root bit per stage) and the two restoring dividers (one quotient
// bit per stage each).
// Reset clears all valid bits, empties the output queue and loads cone_length = 10.0 and
// cone_end_radius = 1.0. When the receiver stalls, the two entry output queue absorbs the
// item leaving the pipe; once it is full the whole pipe holds and query.ready drops, so no
// item is lost or repeated.
module cone_sphere_contact_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    csct_query_if.sink           query,
    csct_result_if.source        result,
    csct_cfg_if.sink             cfg
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * CW + 2;          // squared distance and dot product
    localparam int LW  = 2 * CW;              // squared direction length
    localparam int SW1 = 2 * PW + CW + 3;
    localparam int SW2 = PW + CW + 4;
    localparam int SW3 = PW + 2 * CW + 3;

    localparam logic [63:0] MIN_DIR_SCALE = 64'd1000000;
    // Shortest accepted squared direction: ceil(2^(2*FRAC_BITS) / 1e6)
    localparam logic [63:0] DIR_LIMIT =
        ((64'd1 << (2 * FRAC_BITS)) + (MIN_DIR_SCALE - 64'd1)) / MIN_DIR_SCALE;
    localparam logic signed [CW-1:0] LENGTH_RESET = CW'(64'd10 << FRAC_BITS);
    localparam logic signed [CW-1:0] END_RESET    = CW'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------------------
    logic signed [CW-1:0] cone_length_reg;
    logic signed [CW-1:0] cone_end_radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_length_reg     <= LENGTH_RESET;
            cone_end_radius_reg <= END_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                csct_pkg::REG_CONE_LENGTH:     cone_length_reg     <= cfg.data;
                csct_pkg::REG_CONE_END_RADIUS: cone_end_radius_reg <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // ------------------------------------------------------------------------------------
    // Global advance: the pipe moves whenever the output queue has room
    // ------------------------------------------------------------------------------------
    logic [1:0] count_reg;
    logic       en;

    assign en          = (count_reg != 2'd2);
    assign query.ready = en;

    // ------------------------------------------------------------------------------------
    // Stage 1: sphere center relative to the origin
    // ------------------------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [CW:0]   rx_reg, ry_reg, rz_reg;
    logic signed [CW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [CW-1:0] rad1_reg;
    logic                 blk1_reg;
    logic signed [CW:0]   rx_next, ry_next, rz_next;

    assign rx_next = {query.sphere_x[CW-1], query.sphere_x} - {query.origin_x[CW-1], query.origin_x};
    assign ry_next = {query.sphere_y[CW-1], query.sphere_y} - {query.origin_y[CW-1], query.origin_y};
    assign rz_next = {query.sphere_z[CW-1], query.sphere_z} - {query.origin_z[CW-1], query.origin_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rz_reg   <= rz_next;
            dx_reg   <= query.dir_x;
            dy_reg   <= query.dir_y;
            dz_reg   <= query.dir_z;
            rad1_reg <= query.sphere_radius;
            blk1_reg <= query.blocked;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 2: the nine products
    // ------------------------------------------------------------------------------------
    logic                   v2_reg;
    logic signed [LW-1:0]   ddx_reg, ddy_reg, ddz_reg;
    logic signed [PW-1:0]   rrx_reg, rry_reg, rrz_reg;
    logic signed [2*CW:0]   rdx_reg, rdy_reg, rdz_reg;
    logic signed [CW-1:0]   rad2_reg;
    logic                   blk2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ddx_reg  <= dx_reg * dx_reg;
            ddy_reg  <= dy_reg * dy_reg;
            ddz_reg  <= dz_reg * dz_reg;
            rrx_reg  <= rx_reg * rx_reg;
            rry_reg  <= ry_reg * ry_reg;
            rrz_reg  <= rz_reg * rz_reg;
            rdx_reg  <= rx_reg * dx_reg;
            rdy_reg  <= ry_reg * dy_reg;
            rdz_reg  <= rz_reg * dz_reg;
            rad2_reg <= rad1_reg;
            blk2_reg <= blk1_reg;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 3: sums; range checks feed the root pipe alongside
    // ------------------------------------------------------------------------------------
    logic                 v3_reg;
    logic [LW-1:0]        len2_reg;
    logic [PW-1:0]        dist2_reg;
    logic signed [PW-1:0] dot_reg;
    logic signed [CW-1:0] rad3_reg;
    logic                 blk3_reg;
    logic                 err3;
    logic                 neg3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len2_reg  <= $unsigned(ddx_reg) + $unsigned(ddy_reg) + $unsigned(ddz_reg);
            dist2_reg <= $unsigned(rrx_reg) + $unsigned(rry_reg) + $unsigned(rrz_reg);
            dot_reg   <= PW'(rdx_reg) + PW'(rdy_reg) + PW'(rdz_reg);
            rad3_reg  <= rad2_reg;
            blk3_reg  <= blk2_reg;
        end
    end

    // Flag negative operands, a non-positive length or a direction too short to normalize
    assign err3 = (cone_length_reg <= 0) || (cone_end_radius_reg < 0) || (rad3_reg < 0) ||
                  (len2_reg < LW'(DIR_LIMIT));
    assign neg3 = dot_reg[PW-1];

    // ------------------------------------------------------------------------------------
    // Square root of the squared direction length
    // ------------------------------------------------------------------------------------
    logic            v4;
    logic [CW-1:0]   q4;
    logic [SW1-1:0]  side4;
    logic [PW-1:0]   dot4;
    logic [PW-1:0]   dist2_4;
    logic [CW-1:0]   rad4;

    csct_isqrt_pipe #(
        .RW (CW),
        .SW (SW1)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (len2_reg),
        .side_in   ({dot_reg, dist2_reg, rad3_reg, err3, neg3, blk3_reg}),
        .out_valid (v4),
        .root      (q4),
        .side_out  (side4)
    );

    assign dot4    = side4[SW1-1 -: PW];
    assign dist2_4 = side4[SW1-PW-1 -: PW];
    assign rad4    = side4[CW+2 -: CW];

    // ------------------------------------------------------------------------------------
    // Stage 5: saturation check of dot / root, and the divider's starting remainder
    // ------------------------------------------------------------------------------------
    logic                 v5_reg;
    logic                 ovf5_reg;
    logic [CW-1:0]        rem05_reg;
    logic [CW-2:0]        num5_reg;
    logic [CW-1:0]        q5_reg;
    logic [PW-1:0]        dist2_5_reg;
    logic [CW-1:0]        rad5_reg;
    logic [2:0]           flags5_reg;
    logic [CW+2:0]        high5;
    logic                 ovf_next;

    // Saturate when the quotient would reach 2^(CW-1)
    assign high5    = dot4[PW-1:CW-1];
    assign ovf_next = (high5 >= {3'b000, q4});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf5_reg    <= ovf_next;
            rem05_reg   <= ovf_next ? '0 : high5[CW-1:0];
            num5_reg    <= dot4[CW-2:0];
            q5_reg      <= q4;
            dist2_5_reg <= dist2_4;
            rad5_reg    <= rad4;
            flags5_reg  <= side4[2:0];
        end
    end

    // ------------------------------------------------------------------------------------
    // Axial distance: dot / root
    // ------------------------------------------------------------------------------------
    logic            v_d1;
    logic [CW-2:0]   quo1;
    logic [SW2-1:0]  side_d1;
    logic [CW-1:0]   rad_d1;
    logic [CW-2:0]   axial_next;
    logic            lt_range;
    logic [CW-2:0]   m_next;
    logic signed [CW+1:0] ax_ext;
    logic signed [CW+1:0] rad_ext;
    logic signed [CW+1:0] len_ext;
    logic            miss1_next;

    csct_udiv_pipe #(
        .QW (CW - 1),
        .DW (CW),
        .SW (SW2)
    ) u_div_axial (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .rem_init  (rem05_reg),
        .num_low   (num5_reg),
        .divisor   (q5_reg),
        .side_in   ({dist2_5_reg, rad5_reg, flags5_reg, ovf5_reg}),
        .out_valid (v_d1),
        .quotient  (quo1),
        .side_out  (side_d1)
    );

    assign rad_d1     = side_d1[CW+3 -: CW];
    assign axial_next = side_d1[0] ? '1 : quo1;
    assign lt_range   = ({1'b0, axial_next} < $unsigned(cone_length_reg));
    assign m_next     = lt_range ? axial_next : cone_length_reg[CW-2:0];
    assign ax_ext     = {3'b000, axial_next};
    assign rad_ext    = {{2{rad_d1[CW-1]}}, rad_d1};
    assign len_ext    = {{2{cone_length_reg[CW-1]}}, cone_length_reg};
    // Miss when the sphere lies beyond the far end
    assign miss1_next = ((ax_ext - rad_ext) > len_ext);

    // ------------------------------------------------------------------------------------
    // Stage 6: axial, clamp to range, far end miss
    // ------------------------------------------------------------------------------------
    logic                 v6_reg;
    logic [CW-2:0]        axial6_reg;
    logic [CW-2:0]        m6_reg;
    logic                 miss1_6_reg;
    logic [PW-1:0]        dist2_6_reg;
    logic [CW-1:0]        rad6_reg;
    logic [2:0]           flags6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            axial6_reg  <= axial_next;
            m6_reg      <= m_next;
            miss1_6_reg <= miss1_next;
            dist2_6_reg <= side_d1[SW2-1 -: PW];
            rad6_reg    <= rad_d1;
            flags6_reg  <= side_d1[3:1];
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 7: end radius times clamped axial
    // ------------------------------------------------------------------------------------
    logic                 v7_reg;
    logic [2*CW-3:0]      prod7_reg;
    logic [CW-2:0]        axial7_reg;
    logic                 miss1_7_reg;
    logic [PW-1:0]        dist2_7_reg;
    logic [CW-1:0]        rad7_reg;
    logic [2:0]           flags7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod7_reg   <= (2*CW-2)'(cone_end_radius_reg[CW-2:0]) * (2*CW-2)'(m6_reg);
            axial7_reg  <= axial6_reg;
            miss1_7_reg <= miss1_6_reg;
            dist2_7_reg <= dist2_6_reg;
            rad7_reg    <= rad6_reg;
            flags7_reg  <= flags6_reg;
        end
    end

    // ------------------------------------------------------------------------------------
    // Cone radius at the axial point: product / length (never saturates)
    // ------------------------------------------------------------------------------------
    logic            v_d2;
    logic [CW-2:0]   quo2;
    logic [SW3-1:0]  side_d2;

    csct_udiv_pipe #(
        .QW (CW - 1),
        .DW (CW - 1),
        .SW (SW3)
    ) u_div_width (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .rem_init  (prod7_reg[2*CW-3:CW-1]),
        .num_low   (prod7_reg[CW-2:0]),
        .divisor   (cone_length_reg[CW-2:0]),
        .side_in   ({dist2_7_reg, rad7_reg, flags7_reg, miss1_7_reg, axial7_reg}),
        .out_valid (v_d2),
        .quotient  (quo2),
        .side_out  (side_d2)
    );

    // ------------------------------------------------------------------------------------
    // Stage 8: allowed width = cone radius + sphere radius
    // ------------------------------------------------------------------------------------
    logic                 v8_reg;
    logic [CW-1:0]        width8_reg;
    logic [CW-2:0]        axial8_reg;
    logic [3:0]           flags8_reg;
    logic [PW-1:0]        dist2_8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            width8_reg  <= {1'b0, quo2} + side_d2[2*CW+2 -: CW];
            axial8_reg  <= side_d2[CW-2:0];
            flags8_reg  <= side_d2[CW+2 -: 4];
            dist2_8_reg <= side_d2[SW3-1 -: PW];
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 9: squares of axial and width
    // ------------------------------------------------------------------------------------
    logic                 v9_reg;
    logic [2*CW-3:0]      asq9_reg;
    logic [LW-1:0]        wsq9_reg;
    logic [3:0]           flags9_reg;
    logic [PW-1:0]        dist2_9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            asq9_reg    <= (2*CW-2)'(axial8_reg) * (2*CW-2)'(axial8_reg);
            wsq9_reg    <= LW'(width8_reg) * LW'(width8_reg);
            flags9_reg  <= flags8_reg;
            dist2_9_reg <= dist2_8_reg;
        end
    end

    // Final compare: flags9 = {err, neg, blocked, far end miss}
    logic [LW:0] rhs9;
    logic        miss2;
    logic        res_hit;
    logic        res_status;

    assign rhs9       = (LW+1)'(asq9_reg) + (LW+1)'(wsq9_reg);
    assign miss2      = (dist2_9_reg > PW'(rhs9));
    assign res_status = flags9_reg[3] ? csct_pkg::STATUS_RANGE_ERROR : csct_pkg::STATUS_OK;
    assign res_hit    = !flags9_reg[3] && !flags9_reg[2] && !flags9_reg[0] && !miss2 &&
                        !flags9_reg[1];

    // ------------------------------------------------------------------------------------
    // Valid bits of the stages
    // ------------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= query.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v5_reg <= v4;
            v6_reg <= v_d1;
            v7_reg <= v6_reg;
            v8_reg <= v_d2;
            v9_reg <= v8_reg;
        end
    end

    // ------------------------------------------------------------------------------------
    // Output queue: two entries so the pipe keeps moving while a result waits
    // ------------------------------------------------------------------------------------
    logic q_hit_reg    [2];
    logic q_status_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic push;
    logic pop;

    assign push = en && v9_reg;
    assign pop  = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_hit_reg[wr_ptr_reg]    <= res_hit;
            q_status_reg[wr_ptr_reg] <= res_status;
        end
    end

    assign result.valid  = (count_reg != 2'd0);
    assign result.hit    = q_hit_reg[rd_ptr_reg];
    assign result.status = q_status_reg[rd_ptr_reg];

    // ------------------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("output queue count out of range");

    a_error_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == csct_pkg::STATUS_RANGE_ERROR) |-> !result.hit)
        else $error("range error item reports a hit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v9_reg) && $stable(v1_reg)))
        else $error("pipe moved while stalled");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("full queue changed without a pop");

endmodule

### dv/csct_checker.sv
// Checker for the cone and sphere contact test: predicts each result and compares.
module csct_checker #(
    parameter int W  = 32,
    parameter int FB = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    csct_query_if.sink      query,
    csct_result_if.sink     result,
    csct_cfg_if.sink        cfg,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic hit;
        logic status;
    } contact_t;

    contact_t expected_q[$];
    logic signed [W-1:0] len_reg;
    logic signed [W-1:0] endr_reg;

    // Floor square root of a 128 bit value.
    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n)
                res = cand;
        end
        return res;
    endfunction

    // Floored quotient, saturated to limit.
    function automatic logic [63:0] quot_sat(logic [127:0] n, logic [63:0] d,
                                             logic [63:0] limit);
        logic [127:0] q;
        q = n / {64'd0, d};
        if (q > {64'd0, limit})
            return limit;
        return q[63:0];
    endfunction

    function automatic contact_t contact_predict(
        logic signed [W-1:0] o[3], logic signed [W-1:0] dv[3], logic signed [W-1:0] s[3],
        logic signed [W-1:0] rad, logic blk, logic signed [W-1:0] clen,
        logic signed [W-1:0] cend);
        contact_t res;
        logic signed [W:0]   rv;
        logic signed [127:0] len2, dist2, dot, rhs;
        logic [127:0]        thr;
        logic [63:0]         q, axial, m, width, range, endr;
        res = '{hit: 1'b0, status: csct_pkg::STATUS_OK};
        len2 = '0;
        dist2 = '0;
        dot = '0;
        for (int i = 0; i < 3; i++) begin
            rv = $signed({s[i][W-1], s[i]}) - $signed({o[i][W-1], o[i]});
            len2 += 128'(dv[i]) * 128'(dv[i]);
            dist2 += 128'(rv) * 128'(rv);
            dot += 128'(rv) * 128'(dv[i]);
        end
        thr = ((128'd1 << (2 * FB)) + 128'd999999) / 128'd1000000;
        if (clen <= 0 || cend < 0 || rad < 0 || len2 < $signed(thr)) begin
            res.status = csct_pkg::STATUS_RANGE_ERROR;
            return res;
        end
        if (dot < 0)
            return res;
        q = root_floor(len2);
        axial = quot_sat(dot, q, (64'd1 << (W - 1)) - 1);
        range = 64'(clen);
        endr = 64'(cend);
        if ($signed(axial) - 64'(rad) > 64'(clen))
            return res;
        m = (axial < range) ? axial : range;
        width = quot_sat({64'd0, endr} * {64'd0, m}, range, endr) + 64'(rad);
        rhs = $signed({64'd0, axial} * {64'd0, axial} + {64'd0, width} * {64'd0, width});
        if (dist2 > rhs)
            return res;
        res.hit = !blk;
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        logic signed [W-1:0] o[3], dv[3], s[3];
        contact_t got, want;
        if (!rst_n) begin
            len_reg <= 32'sd655360;
            endr_reg <= 32'sd65536;
            fail_count <= 0;
            expected_q.delete();
        end
        else begin
            if (query.valid && query.ready) begin
                o = '{query.origin_x, query.origin_y, query.origin_z};
                dv = '{query.dir_x, query.dir_y, query.dir_z};
                s = '{query.sphere_x, query.sphere_y, query.sphere_z};
                expected_q.push_back(contact_predict(o, dv, s, query.sphere_radius,
                                                     query.blocked, len_reg, endr_reg));
            end
            if (result.valid && result.ready) begin
                got = '{hit: result.hit, status: result.status};
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result item hit=%0b status=%0b",
                                 got.hit, got.status);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected hit=%0b status=%0b, got hit=%0b status=%0b",
                                     want.hit, want.status, got.hit, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == csct_pkg::REG_CONE_LENGTH)
                    len_reg <= cfg.data;
                else if (cfg.index == csct_pkg::REG_CONE_END_RADIUS)
                    endr_reg <= cfg.data;
            end
        end
    end
endmodule

### dv/tb_top.sv
// Top of the cone and sphere contact test bench: stimulus, idling and verdict.
module tb_top;

    localparam int W       = 32;
    localparam int LATENCY = 3 * W + 7;
    localparam int LIMIT   = 2000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    logic rx_stall_mode;

    csct_query_if  #(.W(W)) query ();
    csct_result_if          result ();
    csct_cfg_if    #(.W(W)) cfg ();

    cone_sphere_contact_test #(.COORD_WIDTH(W), .FRAC_BITS(16)) uut (
        .clk(clk), .rst_n(rst_n), .query(query), .result(result), .cfg(cfg));

    csct_checker #(.W(W), .FB(16)) u_checker (
        .clk(clk), .rst_n(rst_n), .query(query), .result(result), .cfg(cfg),
        .fail_count(fail_count), .pending(pending));

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Abort on a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the receiver in phases: long open stretches, then random stalls.
    always @(posedge clk) begin
        if (!rst_n)
            result.ready <= 1'b0;
        else begin
            if ($urandom_range(0, 199) == 0)
                rx_stall_mode <= ~rx_stall_mode;
            result.ready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Pick a coordinate: mostly small values so geometry stays near the cone.
    function automatic logic [W-1:0] coord_rand();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 32 << 16)) - (16 << 16);
        endcase
    endfunction

    // Send one item and hold until it is accepted.
    task automatic send_query(logic [W-1:0] ox, oy, oz, dx, dy, dz, sx, sy, sz, rad,
                              logic blk);
        query.valid <= 1'b1;
        query.origin_x <= ox;
        query.origin_y <= oy;
        query.origin_z <= oz;
        query.dir_x <= dx;
        query.dir_y <= dy;
        query.dir_z <= dz;
        query.sphere_x <= sx;
        query.sphere_y <= sy;
        query.sphere_z <= sz;
        query.sphere_radius <= rad;
        query.blocked <= blk;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        query.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Build one random item, mostly a well-formed aimed query.
    task automatic send_random();
        logic [W-1:0] o[3], d[3], s[3], rad;
        for (int i = 0; i < 3; i++) begin
            o[i] = coord_rand();
            d[i] = coord_rand();
            s[i] = coord_rand();
        end
        if ($urandom_range(0, 3) != 0) begin
            // aim the sphere along the axis with a small sideways offset
            o = '{$signed($urandom_range(0, 8 << 16)) - (4 << 16), 32'sd0, 32'sd0};
            d = '{32'sd65536 * $urandom_range(1, 3), 32'sd0, 32'sd0};
            if ($urandom_range(0, 1))
                d[1] = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            s[0] = o[0] + $signed($urandom_range(0, 14 << 16)) - (2 << 16);
            s[1] = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
            s[2] = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
            rad = $urandom_range(0, 1 << 16);
        end
        else
            rad = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 3 << 16);
        send_query(o[0], o[1], o[2], d[0], d[1], d[2], s[0], s[1], s[2], rad,
                   $urandom_range(0, 1));
    endtask

    // Drain every expected result, then hold through the pipe latency.
    task automatic drain();
        query.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(csct_pkg::cfg_idx_t idx, logic [W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
        drain();
    endtask

    initial begin
        logic [W-1:0] lens[6];
        logic [W-1:0] ends[6];
        rst_n = 1'b0;
        cycle_count = 0;
        rx_stall_mode = 1'b0;
        query.valid = 1'b0;
        query.origin_x = '0;
        query.origin_y = '0;
        query.origin_z = '0;
        query.dir_x = '0;
        query.dir_y = '0;
        query.dir_z = '0;
        query.sphere_x = '0;
        query.sphere_y = '0;
        query.sphere_z = '0;
        query.sphere_radius = '0;
        query.blocked = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = csct_pkg::REG_CONE_LENGTH;
        cfg.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: hit, blocked hit, behind, beyond, off axis, zero and tiny direction,
        // negative radius, extreme coordinates.
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd327680, 0, 0, 32'sd32768, 1'b0);
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd327680, 0, 0, 32'sd32768, 1'b1);
        send_query(0, 0, 0, 32'sd65536, 0, 0, -32'sd327680, 0, 0, 32'sd32768, 1'b0);
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd1310720, 0, 0, 32'sd32768, 1'b0);
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd327680, 32'sd327680, 0, 32'sd0, 1'b0);
        send_query(0, 0, 0, 0, 0, 0, 32'sd65536, 0, 0, 32'sd65536, 1'b0);
        send_query(0, 0, 0, 32'sd65, 0, 0, 32'sd65536, 0, 0, 32'sd65536, 1'b0);
        send_query(0, 0, 0, 32'sd66, 0, 0, 32'sd65536, 0, 0, 32'sd65536, 1'b0);
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd65536, 0, 0, -32'sd1, 1'b0);
        send_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b1);
        send_query(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_query(0, 0, 0, 32'sd65536, 0, 0, 32'sd720896, 0, 0, 32'sd65536, 1'b0);
        // Pause until every result has come back.
        drain();

        lens = '{32'sd655360, 32'h7fffffff, 32'sd1, 32'sd0, 32'h80000000, 32'sd196608};
        ends = '{32'sd65536, 32'h7fffffff, 32'sd0, -32'sd1, 32'sd131072, 32'h80000000};
        for (int p = 0; p < 6; p++) begin
            write_reg(csct_pkg::REG_CONE_LENGTH, lens[p]);
            write_reg(csct_pkg::REG_CONE_END_RADIUS, ends[p]);
            random_phase(p < 2 ? 500 : 160);
        end
        write_reg(csct_pkg::REG_CONE_LENGTH, 32'sd655360);
        write_reg(csct_pkg::REG_CONE_END_RADIUS, 32'sd65536);
        random_phase(10);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
